>>> sv/rsi_pkg.sv
// Shared constants and register codes for the ray-sphere intersection unit.
// No dependencies.
package rsi_pkg;

  // Fraction bits of coordinates, radius, distance and squared distance.
  localparam int COORD_FRAC_BITS = 16;
  // Fraction bits of unit vectors (Q2.30).
  localparam int UNIT_FRAC = 30;
  // Rounding constant for dropping UNIT_FRAC fraction bits.
  localparam longint UNIT_RND = 64'd1 << (UNIT_FRAC - 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_CENTER_Z,
    CFG_RADIUS
  } cfg_reg_t;

endpackage

>>> sv/rsi_mul.sv
// Two-stage signed multiplier lanes with a sideband that travels alongside.
// Operand A is split in halves; partial products are registered, then summed.
// No dependencies.
module rsi_mul #(
  parameter int N  = 1,
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int SW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vin,
  input  logic [SW-1:0]             side_in,
  input  logic [N-1:0][WA-1:0]      a,
  input  logic [N-1:0][WB-1:0]      b,
  output logic                      vout,
  output logic [SW-1:0]             side_out,
  output logic [N-1:0][WA+WB-1:0]   p
);
  localparam int K  = WA / 2;
  localparam int WH = WA - K;

  logic                    v1;
  logic [SW-1:0]           side1;
  logic [N-1:0][K+WB:0]    pp_lo;
  logic [N-1:0][WH+WB-1:0] pp_hi;

  // Valid bits follow the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      vout <= v1;
    end
  end

  // Partial products, then their weighted sum.
  always_ff @(posedge clk) begin
    if (en) begin
      side1    <= side_in;
      side_out <= side1;
      for (int i = 0; i < N; i++) begin
        pp_lo[i] <= $signed({1'b0, a[i][K-1:0]}) * $signed(b[i]);
        pp_hi[i] <= $signed(a[i][WA-1:K]) * $signed(b[i]);
        p[i]     <= {pp_hi[i], {K{1'b0}}} + (WA+WB)'($signed(pp_lo[i]));
      end
    end
  end

endmodule

>>> sv/rsi_sqrt.sv
// Pipelined integer square root (floor), one root bit per stage.
// Carries a sideband with the same latency. No dependencies.
module rsi_sqrt #(
  parameter int WX = 72,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [SW-1:0]     side_in,
  input  logic [WX-1:0]     x,
  output logic              vout,
  output logic [SW-1:0]     side_out,
  output logic [WX/2-1:0]   root
);
  localparam int WR = WX / 2;

  logic          vld [WR+1];
  logic [SW-1:0] sd  [WR+1];
  logic [WX-1:0] xs  [WR+1];
  logic [WR+2:0] rm  [WR+1];
  logic [WR-1:0] rt  [WR+1];

  assign vld[0] = vin;
  assign sd[0]  = side_in;
  assign xs[0]  = x;
  assign rm[0]  = '0;
  assign rt[0]  = '0;

  for (genvar k = 0; k < WR; k++) begin : g_step
    logic [WR+2:0] acc;
    logic [WR+2:0] trial;

    // Bring down the next two radicand bits and try the next root bit.
    assign acc   = {rm[k][WR:0], xs[k][WX-1:WX-2]};
    assign trial = {1'b0, rt[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1] <= sd[k];
        xs[k+1] <= {xs[k][WX-3:0], 2'b00};
        if (acc >= trial) begin
          rm[k+1] <= acc - trial;
          rt[k+1] <= {rt[k][WR-2:0], 1'b1};
        end else begin
          rm[k+1] <= acc;
          rt[k+1] <= {rt[k][WR-2:0], 1'b0};
        end
      end
    end
  end

  assign vout     = vld[WR];
  assign side_out = sd[WR];
  assign root     = rt[WR];

endmodule

>>> sv/rsi_div.sv
// Pipelined restoring divider lanes sharing one divisor, one quotient bit
// per stage. The quotient must fit in WQ bits. No dependencies.
module rsi_div #(
  parameter int N  = 3,
  parameter int WN = 72,
  parameter int WD = 42,
  parameter int WQ = 31,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vin,
  input  logic [SW-1:0]         side_in,
  input  logic [N-1:0][WN-1:0]  num,
  input  logic [WD-1:0]         den,
  output logic                  vout,
  output logic [SW-1:0]         side_out,
  output logic [N-1:0][WQ-1:0]  q
);
  logic                 vld [WQ+1];
  logic [SW-1:0]        sd  [WQ+1];
  logic [WD-1:0]        dv  [WQ+1];
  logic [N-1:0][WD:0]   rm  [WQ+1];
  logic [N-1:0][WQ-1:0] lq  [WQ+1];

  assign vld[0] = vin;
  assign sd[0]  = side_in;
  assign dv[0]  = den;
  for (genvar i = 0; i < N; i++) begin : g_init
    assign rm[0][i] = (WD+1)'(num[i][WN-1:WQ]);
    assign lq[0][i] = num[i][WQ-1:0];
  end

  for (genvar k = 0; k < WQ; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1] <= sd[k];
        dv[k+1] <= dv[k];
      end
    end

    for (genvar i = 0; i < N; i++) begin : g_lane
      logic [WD:0] acc;

      // Shift in the next dividend bit; the quotient bit enters at the bottom.
      assign acc = {rm[k][i][WD-1:0], lq[k][i][WQ-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          if (acc >= {1'b0, dv[k]}) begin
            rm[k+1][i] <= acc - {1'b0, dv[k]};
            lq[k+1][i] <= {lq[k][i][WQ-2:0], 1'b1};
          end else begin
            rm[k+1][i] <= acc;
            lq[k+1][i] <= {lq[k][i][WQ-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign vout     = vld[WQ];
  assign side_out = sd[WQ];
  assign q        = lq[WQ];

endmodule

>>> sv/ray_sphere_intersection.sv
// Ray-sphere intersection unit: streams rays, tests each against one sphere.
// Depends on rsi_pkg, rsi_mul, rsi_sqrt and rsi_div.
//
//   port group   dir  role
//   s_axis_*     in   ray transactions (origin, direction)
//   m_axis_*     out  result transactions (hit in tuser, fields in tdata)
//   cfg_*        in   register writes (index, data), always ready
//
// One ray is accepted every cycle unless a result waits on m_axis_tready. The
// pipeline depth is set mostly by the three square-root pipelines (36, 42, 40
// stages) and two divider pipelines (31 stages each). Reset clears all valid
// bits and loads the sphere at the origin with radius 1.0. The whole pipeline
// holds while a result waits on m_axis_tready, so a stall loses or repeats
// nothing.
module ray_sphere_intersection #(
  parameter int FRAC_BITS = rsi_pkg::COORD_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [191:0]                   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // distance (31), normal_x/y/z, tangent_x/y/z, bitangent_x/y/z (32 each),
  // dist_sq (48), one zero pad bit
  output logic [367:0]                   m_axis_tdata,
  // hit
  output logic                           m_axis_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rsi_pkg::*;

  localparam logic [70:0] RND = 71'(UNIT_RND);

  typedef struct packed {
    logic [2:0][32:0] oc;
    logic [2:0][31:0] d;
  } sa_t;
  typedef struct packed {
    logic [2:0][32:0] oc;
    logic [2:0][31:0] d;
    logic [36:0]      h;
    logic [66:0]      cw;
  } sb_t;
  typedef struct packed {
    logic             miss;
    logic [2:0][32:0] oc;
    logic [2:0][31:0] d;
    logic [36:0]      h;
    logic             cwneg;
  } sc_t;
  typedef struct packed {
    logic             miss;
    logic [2:0][32:0] oc;
    logic [2:0][31:0] d;
    logic [38:0]      t;
    logic             cwneg;
  } sd_t;
  typedef struct packed {
    logic             miss;
    logic [2:0][31:0] d;
    logic [38:0]      t;
    logic             cwneg;
    logic [2:0][41:0] nr;
  } se_t;
  typedef struct packed {
    logic             miss;
    logic [2:0][31:0] d;
    logic [38:0]      t;
    logic             cwneg;
    logic [2:0][41:0] nr;
    logic [47:0]      dsq;
  } sf_t;
  typedef struct packed {
    logic             miss;
    logic [2:0][31:0] d;
    logic [38:0]      t;
    logic             cwneg;
    logic [2:0]       nrneg;
    logic             lenz;
    logic [47:0]      dsq;
  } sg_t;
  typedef struct packed {
    logic             miss;
    logic [2:0][31:0] d;
    logic [38:0]      t;
    logic [2:0][31:0] n;
    logic [47:0]      dsq;
  } sh_t;
  typedef struct packed {
    logic             miss;
    logic [38:0]      t;
    logic [2:0][31:0] n;
    logic [2:0][38:0] v;
    logic [47:0]      dsq;
  } si_t;
  typedef struct packed {
    logic             miss;
    logic [38:0]      t;
    logic [2:0][31:0] n;
    logic [2:0]       vneg;
    logic             lenz;
    logic [47:0]      dsq;
  } sj_t;
  typedef struct packed {
    logic             miss;
    logic [38:0]      t;
    logic [2:0][31:0] n;
    logic [2:0][31:0] tg;
    logic [47:0]      dsq;
  } sk_t;

  logic en;
  logic [2:0][31:0] center;
  logic [30:0]      radius;

  // Global pipeline advance: hold everything while a result is refused.
  assign en            = ~(m_axis_tvalid & ~m_axis_tready);
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
      radius <= 31'(1) << FRAC_BITS;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CENTER_X: center[0] <= cfg_data;
        CFG_CENTER_Y: center[1] <= cfg_data;
        CFG_CENTER_Z: center[2] <= cfg_data;
        CFG_RADIUS:   radius    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Stage 0: capture the ray and form origin minus center.
  logic v0;
  sa_t  a0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_axis_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a0.oc[i] <= 33'($signed(s_axis_tdata[32*i +: 32])) - 33'($signed(center[i]));
        a0.d[i]  <= s_axis_tdata[96 + 32*i +: 32];
      end
    end
  end

  // dir.oc, |oc|^2 terms and radius squared.
  logic [6:0][32:0] ma_a, ma_b;
  logic [6:0][65:0] ma_p;
  logic             va;
  sa_t              sa_o;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma_a[i]   = 33'($signed(a0.d[i]));
      ma_b[i]   = a0.oc[i];
      ma_a[3+i] = a0.oc[i];
      ma_b[3+i] = a0.oc[i];
    end
    ma_a[6] = {2'b00, radius};
    ma_b[6] = {2'b00, radius};
  end
  rsi_mul #(.N(7), .WA(33), .WB(33), .SW($bits(sa_t))) u_mul_a (
    .clk, .rst, .en, .vin(v0), .side_in(a0), .a(ma_a), .b(ma_b),
    .vout(va), .side_out(sa_o), .p(ma_p));

  // Stage 1: h = round(dir.oc) and c = |oc|^2 - r^2.
  logic [66:0] dsum1, cw1;
  logic        v1;
  sb_t         b1;
  always_comb begin
    dsum1 = 67'($signed(ma_p[0])) + 67'($signed(ma_p[1])) + 67'($signed(ma_p[2]))
          + 67'(RND);
    cw1   = 67'($signed(ma_p[3])) + 67'($signed(ma_p[4])) + 67'($signed(ma_p[5]))
          - 67'($signed(ma_p[6]));
  end
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b1.oc <= sa_o.oc;
      b1.d  <= sa_o.d;
      b1.h  <= dsum1[66:30];
      b1.cw <= cw1;
    end
  end

  // h squared.
  logic [0:0][73:0] mb_p;
  logic             vb;
  sb_t              sb_o;
  rsi_mul #(.N(1), .WA(37), .WB(37), .SW($bits(sb_t))) u_mul_b (
    .clk, .rst, .en, .vin(v1), .side_in(b1), .a(b1.h), .b(b1.h),
    .vout(vb), .side_out(sb_o), .p(mb_p));

  // Stage 2: discriminant; a negative one is a miss.
  logic [74:0] disc2;
  logic        v2;
  sc_t         c2;
  logic [71:0] x2;
  assign disc2 = 75'($signed(mb_p[0])) - 75'($signed(sb_o.cw));
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c2.miss  <= disc2[74];
      c2.oc    <= sb_o.oc;
      c2.d     <= sb_o.d;
      c2.h     <= sb_o.h;
      c2.cwneg <= sb_o.cw[66];
      x2       <= disc2[74] ? '0 : disc2[71:0];
    end
  end

  logic        vs1;
  sc_t         sc_o;
  logic [35:0] root1;
  rsi_sqrt #(.WX(72), .SW($bits(sc_t))) u_sqrt_disc (
    .clk, .rst, .en, .vin(v2), .side_in(c2), .x(x2),
    .vout(vs1), .side_out(sc_o), .root(root1));

  // Stage 3: nearer non-negative root, else the farther one.
  logic [38:0] h3, t_near, t_far, t3;
  logic        v3;
  sd_t         d3;
  always_comb begin
    h3     = 39'($signed(sc_o.h));
    t_near = -h3 - 39'(root1);
    t_far  = -h3 + 39'(root1);
    t3     = t_near[38] ? t_far : t_near;
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= vs1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d3.miss  <= sc_o.miss | t3[38];
      d3.oc    <= sc_o.oc;
      d3.d     <= sc_o.d;
      d3.t     <= t3;
      d3.cwneg <= sc_o.cwneg;
    end
  end

  // t times direction.
  logic [2:0][38:0] mc_a;
  logic [2:0][70:0] mc_p;
  logic             vc;
  sd_t              sd_o;
  assign mc_a = {3{d3.t}};
  rsi_mul #(.N(3), .WA(39), .WB(32), .SW($bits(sd_t))) u_mul_c (
    .clk, .rst, .en, .vin(v3), .side_in(d3), .a(mc_a), .b(d3.d),
    .vout(vc), .side_out(sd_o), .p(mc_p));

  // Stage 4: step vector and unnormalized normal.
  logic [2:0][70:0] rc4;
  logic [2:0][41:0] stp4;
  logic             v4;
  se_t              e4;
  logic [2:0][41:0] stp4_q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rc4[i]  = mc_p[i] + RND;
      stp4[i] = 42'($signed(rc4[i][70:30]));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= vc;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e4.miss  <= sd_o.miss;
      e4.d     <= sd_o.d;
      e4.t     <= sd_o.t;
      e4.cwneg <= sd_o.cwneg;
      stp4_q   <= stp4;
      for (int i = 0; i < 3; i++) begin
        e4.nr[i] <= 42'($signed(sd_o.oc[i])) + stp4[i];
      end
    end
  end

  // Squares of the normal and of the step vector.
  logic [5:0][41:0] md_a;
  logic [5:0][83:0] md_p;
  logic             vd;
  se_t              se_o;
  assign md_a = {stp4_q, e4.nr};
  rsi_mul #(.N(6), .WA(42), .WB(42), .SW($bits(se_t))) u_mul_d (
    .clk, .rst, .en, .vin(v4), .side_in(e4), .a(md_a), .b(md_a),
    .vout(vd), .side_out(se_o), .p(md_p));

  // Stage 5: normal length squared and saturated squared distance.
  logic [83:0] ss5, ds5, dr5;
  logic        v5;
  sf_t         f5;
  logic [83:0] x5;
  always_comb begin
    ss5 = md_p[0] + md_p[1] + md_p[2];
    ds5 = md_p[3] + md_p[4] + md_p[5] + (84'(1) << (FRAC_BITS - 1));
    dr5 = ds5 >> FRAC_BITS;
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= vd;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f5.miss  <= se_o.miss;
      f5.d     <= se_o.d;
      f5.t     <= se_o.t;
      f5.cwneg <= se_o.cwneg;
      f5.nr    <= se_o.nr;
      f5.dsq   <= (|dr5[83:48]) ? '1 : dr5[47:0];
      x5       <= ss5;
    end
  end

  logic        vs2;
  sf_t         sf_o;
  logic [41:0] root2;
  rsi_sqrt #(.WX(84), .SW($bits(sf_t))) u_sqrt_norm (
    .clk, .rst, .en, .vin(v5), .side_in(f5), .x(x5),
    .vout(vs2), .side_out(sf_o), .root(root2));

  // Stage 6: rounded dividends for the normal.
  logic [2:0][41:0] mag6;
  logic             v6;
  sg_t              g6;
  logic [2:0][71:0] num6;
  logic [41:0]      den6;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag6[i] = sf_o.nr[i][41] ? -sf_o.nr[i] : sf_o.nr[i];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= vs2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g6.miss  <= sf_o.miss;
      g6.d     <= sf_o.d;
      g6.t     <= sf_o.t;
      g6.cwneg <= sf_o.cwneg;
      g6.lenz  <= (root2 == '0);
      g6.dsq   <= sf_o.dsq;
      den6     <= root2;
      for (int i = 0; i < 3; i++) begin
        g6.nrneg[i] <= sf_o.nr[i][41];
        num6[i]     <= {mag6[i], 30'b0} + 72'(root2 >> 1);
      end
    end
  end

  logic             vq1;
  sg_t              sg_o;
  logic [2:0][30:0] q1;
  rsi_div #(.N(3), .WN(72), .WD(42), .WQ(31), .SW($bits(sg_t))) u_div_norm (
    .clk, .rst, .en, .vin(v6), .side_in(g6), .num(num6), .den(den6),
    .vout(vq1), .side_out(sg_o), .q(q1));

  // Stage 7: signed unit normal, flipped when the origin is inside; zero for a zero-length normal.
  logic v7;
  sh_t  h7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= vq1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h7.miss <= sg_o.miss;
      h7.d    <= sg_o.d;
      h7.t    <= sg_o.t;
      h7.dsq  <= sg_o.dsq;
      for (int i = 0; i < 3; i++) begin
        if (sg_o.lenz) h7.n[i] <= '0;
        else if (sg_o.nrneg[i] ^ sg_o.cwneg) h7.n[i] <= -{1'b0, q1[i]};
        else h7.n[i] <= {1'b0, q1[i]};
      end
    end
  end

  // dir.n terms.
  logic [2:0][63:0] me_p;
  logic             ve;
  sh_t              sh_e;
  rsi_mul #(.N(3), .WA(32), .WB(32), .SW($bits(sh_t))) u_mul_e (
    .clk, .rst, .en, .vin(v7), .side_in(h7), .a(h7.d), .b(h7.n),
    .vout(ve), .side_out(sh_e), .p(me_p));

  // Stage 8: dn = round(dir.n).
  logic [65:0]      dsum8;
  logic             v8;
  sh_t              h8;
  logic [35:0]      dn8;
  assign dsum8 = 66'($signed(me_p[0])) + 66'($signed(me_p[1])) + 66'($signed(me_p[2]))
               + 66'(RND);
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= ve;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h8  <= sh_e;
      dn8 <= dsum8[65:30];
    end
  end

  // dn times normal.
  logic [2:0][35:0] mf_a;
  logic [2:0][67:0] mf_p;
  logic             vf;
  sh_t              sh_f;
  assign mf_a = {3{dn8}};
  rsi_mul #(.N(3), .WA(36), .WB(32), .SW($bits(sh_t))) u_mul_f (
    .clk, .rst, .en, .vin(v8), .side_in(h8), .a(mf_a), .b(h8.n),
    .vout(vf), .side_out(sh_f), .p(mf_p));

  // Stage 9: direction projected off the normal.
  logic [2:0][67:0] rc9;
  logic             v9;
  si_t              i9;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rc9[i] = mf_p[i] + 68'(RND);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= vf;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      i9.miss <= sh_f.miss;
      i9.t    <= sh_f.t;
      i9.n    <= sh_f.n;
      i9.dsq  <= sh_f.dsq;
      for (int i = 0; i < 3; i++) begin
        i9.v[i] <= 39'($signed(sh_f.d[i])) - 39'($signed(rc9[i][67:30]));
      end
    end
  end

  // Squares of the projected vector.
  logic [2:0][77:0] mg_p;
  logic             vg;
  si_t              si_o;
  rsi_mul #(.N(3), .WA(39), .WB(39), .SW($bits(si_t))) u_mul_g (
    .clk, .rst, .en, .vin(v9), .side_in(i9), .a(i9.v), .b(i9.v),
    .vout(vg), .side_out(si_o), .p(mg_p));

  // Stage 10: projected vector length squared.
  logic        v10;
  si_t         i10;
  logic [79:0] x10;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= vg;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      i10 <= si_o;
      x10 <= 80'(mg_p[0]) + 80'(mg_p[1]) + 80'(mg_p[2]);
    end
  end

  logic        vs3;
  si_t         si_s;
  logic [39:0] root3;
  rsi_sqrt #(.WX(80), .SW($bits(si_t))) u_sqrt_tan (
    .clk, .rst, .en, .vin(v10), .side_in(i10), .x(x10),
    .vout(vs3), .side_out(si_s), .root(root3));

  // Stage 11: rounded dividends for the tangent.
  logic [2:0][38:0] mag11;
  logic             v11;
  sj_t              j11;
  logic [2:0][68:0] num11;
  logic [39:0]      den11;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag11[i] = si_s.v[i][38] ? -si_s.v[i] : si_s.v[i];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= vs3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      j11.miss <= si_s.miss;
      j11.t    <= si_s.t;
      j11.n    <= si_s.n;
      j11.dsq  <= si_s.dsq;
      j11.lenz <= (root3 == '0);
      den11    <= root3;
      for (int i = 0; i < 3; i++) begin
        j11.vneg[i] <= si_s.v[i][38];
        num11[i]    <= {mag11[i], 30'b0} + 69'(root3 >> 1);
      end
    end
  end

  logic             vq2;
  sj_t              sj_o;
  logic [2:0][30:0] q2;
  rsi_div #(.N(3), .WN(69), .WD(40), .WQ(31), .SW($bits(sj_t))) u_div_tan (
    .clk, .rst, .en, .vin(v11), .side_in(j11), .num(num11), .den(den11),
    .vout(vq2), .side_out(sj_o), .q(q2));

  // Stage 12: signed unit tangent; zero when the projection vanishes.
  logic v12;
  sk_t  k12;
  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= vq2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      k12.miss <= sj_o.miss;
      k12.t    <= sj_o.t;
      k12.n    <= sj_o.n;
      k12.dsq  <= sj_o.dsq;
      for (int i = 0; i < 3; i++) begin
        if (sj_o.lenz) k12.tg[i] <= '0;
        else if (sj_o.vneg[i]) k12.tg[i] <= -{1'b0, q2[i]};
        else k12.tg[i] <= {1'b0, q2[i]};
      end
    end
  end

  // Cross product terms of normal and tangent.
  logic [5:0][31:0] mh_a, mh_b;
  logic [5:0][63:0] mh_p;
  logic             vh;
  sk_t              sk_o;
  assign mh_a = {k12.n[1], k12.n[0], k12.n[0], k12.n[2], k12.n[2], k12.n[1]};
  assign mh_b = {k12.tg[0], k12.tg[1], k12.tg[2], k12.tg[0], k12.tg[1], k12.tg[2]};
  rsi_mul #(.N(6), .WA(32), .WB(32), .SW($bits(sk_t))) u_mul_h (
    .clk, .rst, .en, .vin(v12), .side_in(k12), .a(mh_a), .b(mh_b),
    .vout(vh), .side_out(sk_o), .p(mh_p));

  // Stage 13: output register; a miss clears every field.
  logic [2:0][64:0] bd13;
  logic             o_vld, o_hit;
  logic [30:0]      o_dist;
  logic [2:0][31:0] o_n, o_tg, o_bt;
  logic [47:0]      o_dsq;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bd13[i] = 65'($signed(mh_p[2*i])) - 65'($signed(mh_p[2*i+1])) + 65'(RND);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) o_vld <= 1'b0;
    else if (en) o_vld <= vh;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (sk_o.miss) begin
        o_hit  <= 1'b0;
        o_dist <= '0;
        o_n    <= '0;
        o_tg   <= '0;
        o_bt   <= '0;
        o_dsq  <= '0;
      end else begin
        o_hit  <= 1'b1;
        o_dist <= (|sk_o.t[38:31]) ? '1 : sk_o.t[30:0];
        o_n    <= sk_o.n;
        o_tg   <= sk_o.tg;
        o_dsq  <= sk_o.dsq;
        for (int i = 0; i < 3; i++) begin
          o_bt[i] <= bd13[i][61:30];
        end
      end
    end
  end

  assign m_axis_tvalid = o_vld;
  assign m_axis_tuser  = o_hit;
  assign m_axis_tdata  = {1'b0, o_dsq, o_bt, o_tg, o_n, o_dist};

`ifndef SYNTHESIS
  // A miss never carries nonzero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss result with nonzero fields");

  // The x component of a computed unit normal never exceeds one in magnitude.
  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (($signed(o_n[0]) <= 32'sd1073741824) && ($signed(o_n[0]) >= -32'sd1073741824)))
    else $error("normal component out of range");
`endif

endmodule
